// ----- rtl/core/spi_master_transaction_engine_top_defines.svh -----
// Assertion macros for the SPI master transaction engine.
// Depends on nothing; every user names its clock clk_i and its reset rst_ni.
`ifndef SPI_MASTER_TRANSACTION_ENGINE_TOP_DEFINES_SVH
`define SPI_MASTER_TRANSACTION_ENGINE_TOP_DEFINES_SVH

// Same-cycle check, off during reset
`define SMTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Next-cycle check: antecedent this edge, consequent at the next edge
`define SMTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/smte_pkg.sv -----
// Package for the SPI master transaction engine: register indexes, widths, result word.
// No dependencies.
package smte_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_CLOCK_RATE   = 3'd0,
    CFG_CLOCK_MODE   = 3'd1,
    CFG_XFER_LENGTH  = 3'd2,
    CFG_SEND_FILL    = 3'd3,
    CFG_KEEP_READ    = 3'd4
  } cfg_reg_e;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned RateW     = 16;
  localparam int unsigned LenW      = 16;
  // kHz * 1000 with 16-bit kHz fits in 26 bits
  localparam int unsigned WantW     = 26;
  localparam int unsigned KhzMultW  = 10;
  localparam logic [KhzMultW-1:0] KHZ_TO_HZ = 10'd1000;
  // Largest divider select (divide by 128)
  localparam logic [2:0] MAX_DIV_SEL = 3'd6;
  localparam logic [7:0] FILL_BYTE   = 8'hFF;

  localparam logic [RateW-1:0] RESET_RATE_KHZ = 16'd1000;
  localparam logic [WantW-1:0] RESET_WANT_HZ  = 26'd1000000;

  // One result word
  typedef struct packed {
    logic            sclk;
    logic            mosi;
    logic            tx_taken;
    logic            rx_valid;
    logic [7:0]      rx_byte;
    logic [LenW-1:0] rx_index;
    logic            busy;
    logic            done;
    logic [LenW-1:0] done_length;
  } result_t;

endpackage

// ----- rtl/core/spi_master_transaction_engine_top.sv -----
// SPI master transaction engine, top level.
// Depends on smte_pkg and spi_master_transaction_engine_top_defines.svh.
//
// Each input word is one system clock tick (start request, transmit byte and
// MISO level) and yields exactly one result word, registered, carrying the
// SCLK and MOSI levels, byte handoff, received bytes and the done pulse. A new
// word is accepted every cycle; the only hold-off is a result word still
// waiting in the output register while out_stall_i is high. The SCLK half
// period is 1 << sel accepted words, sel (0..6) being picked once at start
// from a compare of the registered clock_rate_khz*1000 against six constant
// thresholds; the product itself is formed when the rate register is written.
`include "spi_master_transaction_engine_top_defines.svh"

module spi_master_transaction_engine_top #(
  parameter int unsigned SYS_CLOCK_HZ = 16000000
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [smte_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [smte_pkg::CfgDataW-1:0] cfg_data_i,
  // input words
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          start_req_i,
  input  logic [7:0]                    tx_byte_i,
  input  logic                          miso_i,
  // result words
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          sclk_o,
  output logic                          mosi_o,
  output logic                          tx_taken_o,
  output logic                          rx_valid_o,
  output logic [7:0]                    rx_byte_o,
  output logic [smte_pkg::LenW-1:0]     rx_index_o,
  output logic                          busy_res_o,
  output logic                          done_res_o,
  output logic [smte_pkg::LenW-1:0]     done_length_o
);

  localparam int unsigned LenW = smte_pkg::LenW;
  localparam int unsigned WantW = smte_pkg::WantW;
  localparam logic [31:0] HALF_SYS_HZ = 32'(SYS_CLOCK_HZ / 2);

  // Configuration registers
  logic [WantW-1:0]           want_hz_q;
  logic [1:0]                 mode_q;
  logic [LenW-1:0]            xfer_len_q;
  logic                       send_fill_q;
  logic                       keep_read_q;

  // Engine state
  logic            active_q, active_d;
  logic [LenW-1:0] byte_cnt_q, byte_cnt_d;
  logic [2:0]      bit_cnt_q, bit_cnt_d;
  logic [7:0]      tx_shift_q, tx_shift_d;
  logic [7:0]      rx_shift_q, rx_shift_d;
  logic [2:0]      div_sel_q, div_sel_d;
  logic [6:0]      div_cnt_q, div_cnt_d;
  logic            clk_lvl_q, clk_lvl_d;

  // Output register
  logic              out_valid_q;
  smte_pkg::result_t res_q, res_d;

  logic       in_accept;
  logic [2:0] sel_pick;
  logic       half_end;

  // Accept unless a held result is being stalled
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  // Configuration writes; the rate is kept as Hz for the divider pick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      want_hz_q   <= smte_pkg::RESET_WANT_HZ;
      mode_q      <= 2'd0;
      xfer_len_q  <= '0;
      send_fill_q <= 1'b0;
      keep_read_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        smte_pkg::CFG_CLOCK_RATE: begin
          want_hz_q <= WantW'(cfg_data_i) * WantW'(smte_pkg::KHZ_TO_HZ);
        end
        smte_pkg::CFG_CLOCK_MODE:  mode_q      <= cfg_data_i[1:0];
        smte_pkg::CFG_XFER_LENGTH: xfer_len_q  <= cfg_data_i;
        smte_pkg::CFG_SEND_FILL:   send_fill_q <= cfg_data_i[0];
        smte_pkg::CFG_KEEP_READ:   keep_read_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Divider pick: lowest sel whose SCLK rate is at or below the request
  always_comb begin
    sel_pick = smte_pkg::MAX_DIV_SEL;
    for (int k = int'(smte_pkg::MAX_DIV_SEL) - 1; k >= 0; k--) begin
      if ((HALF_SYS_HZ >> k) <= 32'(want_hz_q)) begin
        sel_pick = 3'(k);
      end
    end
  end

  // End of the current SCLK half period
  assign half_end = ({1'b0, div_cnt_q} + 8'd1) >= (8'd1 << div_sel_q);

  // One tick of the engine
  always_comb begin
    active_d   = active_q;
    byte_cnt_d = byte_cnt_q;
    bit_cnt_d  = bit_cnt_q;
    tx_shift_d = tx_shift_q;
    rx_shift_d = rx_shift_q;
    div_sel_d  = div_sel_q;
    div_cnt_d  = div_cnt_q;
    clk_lvl_d  = clk_lvl_q;
    res_d      = '0;

    if (!active_q) begin
      if (start_req_i) begin
        div_sel_d = sel_pick;
        if (xfer_len_q == '0) begin
          res_d.done = 1'b1;
        end else begin
          active_d   = 1'b1;
          byte_cnt_d = '0;
          bit_cnt_d  = '0;
          div_cnt_d  = '0;
          clk_lvl_d  = 1'b0;
          rx_shift_d = '0;
          tx_shift_d = send_fill_q ? smte_pkg::FILL_BYTE : tx_byte_i;
          res_d.tx_taken = ~send_fill_q;
        end
      end
    end else if (half_end) begin
      div_cnt_d = '0;
      clk_lvl_d = ~clk_lvl_q;
      if (!clk_lvl_q) begin
        // leading edge
        if (!mode_q[0]) begin
          rx_shift_d = {rx_shift_q[6:0], miso_i};
        end else if (bit_cnt_q != 3'd0) begin
          tx_shift_d = {tx_shift_q[6:0], 1'b0};
        end
      end else begin
        // trailing edge, bit complete
        if (!mode_q[0]) begin
          tx_shift_d = {tx_shift_q[6:0], 1'b0};
        end else begin
          rx_shift_d = {rx_shift_q[6:0], miso_i};
        end
        bit_cnt_d = bit_cnt_q + 3'd1;
        if (bit_cnt_q == 3'd7) begin
          if (keep_read_q) begin
            res_d.rx_valid = 1'b1;
            res_d.rx_byte  = rx_shift_d;
            res_d.rx_index = byte_cnt_q;
          end
          byte_cnt_d = byte_cnt_q + LenW'(1);
          if (byte_cnt_d < xfer_len_q) begin
            tx_shift_d = send_fill_q ? smte_pkg::FILL_BYTE : tx_byte_i;
            res_d.tx_taken = ~send_fill_q;
          end else begin
            active_d          = 1'b0;
            res_d.done        = 1'b1;
            res_d.done_length = byte_cnt_d;
          end
        end
      end
    end else begin
      div_cnt_d = div_cnt_q + 7'd1;
    end

    res_d.sclk = mode_q[1] ^ clk_lvl_d;
    res_d.mosi = active_d & tx_shift_d[7];
    res_d.busy = active_d;
  end

  // State advances once per accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      byte_cnt_q <= '0;
      bit_cnt_q  <= '0;
      tx_shift_q <= '0;
      rx_shift_q <= '0;
      div_sel_q  <= '0;
      div_cnt_q  <= '0;
      clk_lvl_q  <= 1'b0;
    end else if (in_accept) begin
      active_q   <= active_d;
      byte_cnt_q <= byte_cnt_d;
      bit_cnt_q  <= bit_cnt_d;
      tx_shift_q <= tx_shift_d;
      rx_shift_q <= rx_shift_d;
      div_sel_q  <= div_sel_d;
      div_cnt_q  <= div_cnt_d;
      clk_lvl_q  <= clk_lvl_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sclk_o        = res_q.sclk;
  assign mosi_o        = res_q.mosi;
  assign tx_taken_o    = res_q.tx_taken;
  assign rx_valid_o    = res_q.rx_valid;
  assign rx_byte_o     = res_q.rx_byte;
  assign rx_index_o    = res_q.rx_index;
  assign busy_res_o    = res_q.busy;
  assign done_res_o    = res_q.done;
  assign done_length_o = res_q.done_length;

  // Checks
  `SMTE_ASSERT(a_div_cnt_in_range,
      !active_q || ({1'b0, div_cnt_q} < (8'd1 << div_sel_q)),
      "divider count beyond half period")
  `SMTE_ASSERT(a_done_not_busy,
      !out_valid_o || !(done_res_o && (busy_res_o || tx_taken_o)),
      "done reported with busy or byte handoff")
  `SMTE_ASSERT(a_empty_never_stalls, out_valid_q || !in_stall_o,
      "input stalled with empty result register")
  `SMTE_ASSERT_NEXT(a_level_holds, in_accept && active_q && !half_end,
      $stable(clk_lvl_q) && $stable(bit_cnt_q),
      "SCLK level moved without a half period end")

endmodule

// ----- tb/sv/spi_master_transaction_engine_top_tb.sv -----
// Self-checking testbench for spi_master_transaction_engine_top: directed table, then random
// transaction phases, each result word checked against its table value or a cycle model of the engine.
// Depends on smte_pkg and the RTL of the top level.
`timescale 1ns / 100ps

module spi_master_transaction_engine_top_tb;

  localparam int unsigned SYS_HZ = 16000000;
  // Words of random phases at ordinary rates, then one slow phase at divider 128
  localparam int unsigned PHASE_WORDS = 650;
  localparam int unsigned SLOW_WORDS = 200;
  // With less room than this left, a phase keeps to the three fastest dividers
  localparam int unsigned FAST_ROOM = 520;
  localparam int unsigned HOLD_AFTER = 200;
  localparam int unsigned HOLD_CYCLES = 100;
  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int unsigned REPORT_MAX = 50;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [smte_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [smte_pkg::CfgDataW-1:0] cfg_data_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic                          start_req_i;
  logic [7:0]                    tx_byte_i;
  logic                          miso_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic                          sclk_o;
  logic                          mosi_o;
  logic                          tx_taken_o;
  logic                          rx_valid_o;
  logic [7:0]                    rx_byte_o;
  logic [smte_pkg::LenW-1:0]     rx_index_o;
  logic                          busy_res_o;
  logic                          done_res_o;
  logic [smte_pkg::LenW-1:0]     done_length_o;

  spi_master_transaction_engine_top #(
    .SYS_CLOCK_HZ(SYS_HZ)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .start_req_i   (start_req_i),
    .tx_byte_i     (tx_byte_i),
    .miso_i        (miso_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sclk_o        (sclk_o),
    .mosi_o        (mosi_o),
    .tx_taken_o    (tx_taken_o),
    .rx_valid_o    (rx_valid_o),
    .rx_byte_o     (rx_byte_o),
    .rx_index_o    (rx_index_o),
    .busy_res_o    (busy_res_o),
    .done_res_o    (done_res_o),
    .done_length_o (done_length_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Engine model: registers
  logic [15:0] rate_khz;
  logic [1:0]  spi_mode;
  logic [15:0] xfer_len;
  logic        fill_on;
  logic        keep_rx;
  // Engine model: transaction state
  logic        xfer_on;
  logic [15:0] byte_cnt;
  logic [2:0]  bit_cnt;
  logic [7:0]  tx_sr;
  logic [7:0]  rx_sr;
  logic [2:0]  sel_q;
  logic [6:0]  div_cnt;
  logic        lvl;

  smte_pkg::result_t spi_words_q[$];
  int unsigned mismatches = 0;
  bit tx_burst = 1'b0;
  // Long receiver hold: requested by the stimulus, taken up by the receiver
  bit hold_req = 1'b0;
  bit hold_on = 1'b0;

  task automatic model_reset();
    rate_khz = smte_pkg::RESET_RATE_KHZ;
    spi_mode = '0;
    xfer_len = '0;
    fill_on  = 1'b0;
    keep_rx  = 1'b1;
    xfer_on  = 1'b0;
    byte_cnt = '0;
    bit_cnt  = '0;
    tx_sr    = '0;
    rx_sr    = '0;
    sel_q    = '0;
    div_cnt  = '0;
    lvl      = 1'b0;
  endtask

  // First divider (2 << sel) whose SCLK rate is at or below the request
  function automatic logic [2:0] div_sel_for(input logic [15:0] khz);
    int unsigned freq;
    int unsigned want;
    logic [2:0]  sel;
    freq = SYS_HZ / 2;
    want = int'(khz) * int'(smte_pkg::KHZ_TO_HZ);
    sel = '0;
    while (sel < smte_pkg::MAX_DIV_SEL && freq > want) begin
      freq = freq / 2;
      sel++;
    end
    return sel;
  endfunction

  // Load the next transmit byte; reports whether tx_byte was consumed
  function automatic logic load_byte(input logic [7:0] tb);
    if (fill_on) begin
      tx_sr = smte_pkg::FILL_BYTE;
      return 1'b0;
    end
    tx_sr = tb;
    return 1'b1;
  endfunction

  // One system tick of the engine
  function automatic smte_pkg::result_t spi_tick(input logic st, input logic [7:0] tb,
                                                 input logic mi);
    smte_pkg::result_t r;
    r = '0;
    if (!xfer_on) begin
      if (st) begin
        sel_q = div_sel_for(rate_khz);
        if (xfer_len == '0) begin
          r.done = 1'b1;
        end else begin
          xfer_on  = 1'b1;
          byte_cnt = '0;
          bit_cnt  = '0;
          div_cnt  = '0;
          lvl      = 1'b0;
          rx_sr    = '0;
          r.tx_taken = load_byte(tb);
        end
      end
    end else if (int'(div_cnt) + 1 >= (1 << sel_q)) begin
      div_cnt = '0;
      lvl = ~lvl;
      if (lvl) begin
        // leading edge
        if (!spi_mode[0]) rx_sr = {rx_sr[6:0], mi};
        else if (bit_cnt != '0) tx_sr = {tx_sr[6:0], 1'b0};
      end else begin
        // trailing edge, bit complete
        if (!spi_mode[0]) tx_sr = {tx_sr[6:0], 1'b0};
        else rx_sr = {rx_sr[6:0], mi};
        bit_cnt = bit_cnt + 3'd1;
        if (bit_cnt == '0) begin
          if (keep_rx) begin
            r.rx_valid = 1'b1;
            r.rx_byte  = rx_sr;
            r.rx_index = byte_cnt;
          end
          byte_cnt = byte_cnt + 16'd1;
          if (byte_cnt < xfer_len) begin
            r.tx_taken = load_byte(tb);
          end else begin
            xfer_on = 1'b0;
            r.done = 1'b1;
            r.done_length = byte_cnt;
          end
        end
      end
    end else begin
      div_cnt = div_cnt + 7'd1;
    end
    r.sclk = spi_mode[1] ^ lvl;
    r.mosi = xfer_on ? tx_sr[7] : 1'b0;
    r.busy = xfer_on;
    return r;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 88) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  task automatic log_mismatch(input string msg);
    if (mismatches < REPORT_MAX) $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      log_mismatch($sformatf("%s got %0h expected %0h", what, got, want));
  endtask

  // Offer one word, hold it until accepted, then record what it must produce
  task automatic drive_tick(input logic st, input logic [7:0] tb, input logic mi,
                            input bit typed = 1'b0,
                            input smte_pkg::result_t want = '0);
    int unsigned       gap;
    smte_pkg::result_t pred;
    gap = tx_burst ? 0 : gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    start_req_i <= st;
    tx_byte_i   <= tb;
    miso_i      <= mi;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pred = spi_tick(st, tb, mi);
    spi_words_q.push_back(typed ? want : pred);
  endtask

  task automatic random_tick(input logic st);
    drive_tick(st, 8'($urandom()), 1'($urandom()));
  endtask

  // Ticks of one phase: noise (kind 0), cut short (kind 1) or one whole transaction
  task automatic run_phase(input int unsigned kind, input int unsigned est,
                           output int unsigned n);
    int unsigned stop;
    n = 0;
    if (kind == 0) begin
      // noise: starts anywhere
      repeat (30) random_tick($urandom_range(0, 3) == 0);
      n = 30;
    end else begin
      // finish whatever transaction is still running, then start a new one
      while (xfer_on) begin
        random_tick(1'b0);
        n++;
      end
      repeat ($urandom_range(0, 2)) begin
        random_tick(1'b0);
        n++;
      end
      random_tick(1'b1);
      n++;
      stop = (kind == 1) ? $urandom_range(1, est) : est;
      for (int unsigned k = 1; k < stop; k++) random_tick($urandom_range(0, 24) == 0);
      n += stop - 1;
      if (kind != 1) begin
        repeat ($urandom_range(0, 3)) begin
          random_tick(1'b0);
          n++;
        end
      end
    end
  endtask

  // Stop offering words and let every result word come back
  task automatic settle();
    in_valid_i <= 1'b0;
    while (spi_words_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Caller lowers cfg_we_i after the last write of a batch
  task automatic cfg_write(input smte_pkg::cfg_reg_e idx, input logic [15:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    unique case (idx)
      smte_pkg::CFG_CLOCK_RATE:  rate_khz = data;
      smte_pkg::CFG_CLOCK_MODE:  spi_mode = data[1:0];
      smte_pkg::CFG_XFER_LENGTH: xfer_len = data;
      smte_pkg::CFG_SEND_FILL:   fill_on  = data[0];
      smte_pkg::CFG_KEEP_READ:   keep_rx  = data[0];
      default: ;
    endcase
  endtask

  // Directed table
  typedef struct {
    bit                  is_cfg;
    smte_pkg::cfg_reg_e  idx;
    logic [15:0]         data;
    logic                st;
    logic [7:0]          tb;
    logic                mi;
    bit                  typed;
    smte_pkg::result_t   want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic void add_tick(input logic st, input logic [7:0] tb, input logic mi,
                                   input bit typed = 1'b0,
                                   input smte_pkg::result_t want = '0);
    dir_row_t row;
    row = '{is_cfg: 1'b0, idx: smte_pkg::CFG_CLOCK_RATE, data: '0, st: st, tb: tb, mi: mi,
            typed: typed, want: want};
    dir_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input smte_pkg::cfg_reg_e idx, input logic [15:0] data);
    dir_row_t row;
    row = '{is_cfg: 1'b1, idx: idx, data: data, st: 1'b0, tb: '0, mi: 1'b0,
            typed: 1'b0, want: '0};
    dir_rows.push_back(row);
  endfunction

  // Result word checker
  always @(posedge clk_i) begin
    smte_pkg::result_t w;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (spi_words_q.size() == 0) begin
        log_mismatch("result word with nothing expected");
      end else begin
        w = spi_words_q.pop_front();
        check_field("sclk", sclk_o, w.sclk);
        check_field("mosi", mosi_o, w.mosi);
        check_field("tx_taken", tx_taken_o, w.tx_taken);
        check_field("rx_valid", rx_valid_o, w.rx_valid);
        check_field("rx_byte", rx_byte_o, w.rx_byte);
        check_field("rx_index", rx_index_o, w.rx_index);
        check_field("busy", busy_res_o, w.busy);
        check_field("done", done_res_o, w.done);
        check_field("done_length", done_length_o, w.done_length);
      end
    end
  end

  // Watchdog: cycles without any word moving on either side
  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Receiver stalls, with one long hold so the engine backs up
  initial begin : rx_side
    int unsigned n;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req && !hold_on) begin
        hold_on = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        n = gap_len();
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(30, 60)) @(posedge clk_i);
      else repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  // Stimulus
  initial begin : stim
    smte_pkg::result_t idle_res;
    smte_pkg::result_t zero_done;
    bit                in_cfg;
    bit                hold_issued;
    int unsigned       rnd_words;
    int unsigned       r;
    int unsigned       kind;
    int unsigned       est;
    int unsigned       n;
    logic [15:0]       rate;
    logic [15:0]       len;
    logic [2:0]        sel_new;

    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= smte_pkg::CFG_CLOCK_RATE;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    start_req_i <= 1'b0;
    tx_byte_i   <= '0;
    miso_i      <= 1'b0;
    model_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_res = '0;
    zero_done = '0;
    zero_done.done = 1'b1;

    // Idle ticks at field extremes, zero-length starts (reset rate, then rate zero)
    add_tick(1'b0, 8'h00, 1'b0, 1'b1, idle_res);
    add_tick(1'b0, 8'hFF, 1'b1, 1'b1, idle_res);
    add_tick(1'b1, 8'hA5, 1'b1, 1'b1, zero_done);
    add_cfg(smte_pkg::CFG_CLOCK_RATE, 16'd0);
    add_tick(1'b1, 8'h5A, 1'b0, 1'b1, zero_done);
    // One byte at the fastest divider in mode 3, with a start while busy
    add_cfg(smte_pkg::CFG_CLOCK_RATE, 16'hFFFF);
    add_cfg(smte_pkg::CFG_CLOCK_MODE, 16'd3);
    add_cfg(smte_pkg::CFG_XFER_LENGTH, 16'd1);
    add_cfg(smte_pkg::CFG_KEEP_READ, 16'd1);
    add_tick(1'b1, 8'h81, 1'b0);
    for (int k = 0; k < 16; k++) add_tick(k == 5, 8'hFF, 1'((k * 5) >> 1));
    add_tick(1'b0, 8'h00, 1'b0);

    in_cfg = 1'b0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        if (!in_cfg) begin
          settle();
          in_cfg = 1'b1;
        end
        cfg_write(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        if (in_cfg) begin
          cfg_we_i <= 1'b0;
          in_cfg = 1'b0;
        end
        drive_tick(dir_rows[i].st, dir_rows[i].tb, dir_rows[i].mi,
                   dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random phases: reconfigure while drained, then run transactions
    rnd_words = 0;
    hold_issued = 1'b0;
    while (rnd_words < PHASE_WORDS) begin
      settle();
      if (PHASE_WORDS - rnd_words < FAST_ROOM) r = $urandom_range(0, 84);
      else r = $urandom_range(0, 99);
      if (r < 5) rate = 16'hFFFF;
      else if (r < 50) rate = 16'($urandom_range(8000, 65535));
      else if (r < 70) rate = 16'($urandom_range(4000, 7999));
      else if (r < 85) rate = 16'($urandom_range(2000, 3999));
      else if (r < 95) rate = 16'($urandom_range(1000, 1999));
      else rate = 16'($urandom_range(250, 999));
      cfg_write(smte_pkg::CFG_CLOCK_RATE, rate);
      sel_new = div_sel_for(rate);
      if (sel_new >= 3'd4) begin
        len = 16'd1;
      end else if (sel_new == 3'd3) begin
        len = 16'($urandom_range(1, 2));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 6) len = 16'd0;
        else if (r < 10 && sel_new <= 3'd1 && !xfer_on) len = 16'hFFFF;
        else len = 16'($urandom_range(1, 6));
      end
      cfg_write(smte_pkg::CFG_XFER_LENGTH, len);
      if ($urandom_range(0, 1)) cfg_write(smte_pkg::CFG_CLOCK_MODE, 16'($urandom()));
      if ($urandom_range(0, 3) == 0) cfg_write(smte_pkg::CFG_SEND_FILL, 16'($urandom()));
      if ($urandom_range(0, 3) == 0)
        cfg_write(smte_pkg::CFG_KEEP_READ,
                  {15'($urandom()), 1'($urandom_range(0, 3) != 0)});
      cfg_we_i <= 1'b0;

      tx_burst = ($urandom_range(0, 3) == 0);
      if (!hold_issued && rnd_words >= HOLD_AFTER) begin
        hold_req = 1'b1;
        hold_issued = 1'b1;
        wait (hold_on);
      end

      if (len == 16'hFFFF) est = $urandom_range(20, 200);
      else est = 1 + int'(len) * 16 * (1 << sel_new);
      // slower dividers always run their transaction to the end
      kind = (sel_new > 3'd2) ? $urandom_range(2, 9) : $urandom_range(0, 9);
      run_phase(kind, est, n);
      rnd_words += n;
    end

    // Zero or tiny rate: divider 128, run for a few SCLK half periods
    settle();
    rate = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(1, 249));
    cfg_write(smte_pkg::CFG_CLOCK_RATE, rate);
    cfg_write(smte_pkg::CFG_XFER_LENGTH, 16'd1);
    cfg_we_i <= 1'b0;
    run_phase(2, SLOW_WORDS, n);
    rnd_words += n;

    settle();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- spi_master_transaction_engine_top.f -----
+incdir+rtl/core
rtl/core/smte_pkg.sv
rtl/core/spi_master_transaction_engine_top.sv
tb/sv/spi_master_transaction_engine_top_tb.sv
